>>> hw/rtl/rsb_pkg.sv
// Shared widths, constants and register map of the radial splat brush.
package rsb_pkg;

  localparam int MAG_W  = 31;
  localparam int SQ_W   = 63;
  localparam int ROOT_W = 32;
  localparam int SIDE_W = 32;

  localparam logic [31:0] FALLOFF_SPAN = 32'd2560;
  localparam logic [18:0] RECIP_FIVE   = 19'd419431;
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;
  localparam logic [16:0] UNIT_Q16     = 17'h10000;
  localparam logic [7:0]  WEIGHT_FULL  = 8'd255;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Z  = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_CELL_SIZE = 3'd3,
    REG_TEX_W     = 3'd4,
    REG_TEX_H     = 3'd5,
    REG_CHANNEL   = 3'd6
  } reg_idx_t;

endpackage

>>> hw/rtl/radial_splat_brush_pixel.sv
// Radial smoothstep brush top level: config registers, pipeline and blend.
// A beat passes stages 1-5, the square root, stages 6-9 and the output register.
// One beat per cycle unless stalled; the 32-stage square root sets the depth.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Synchronous active-low reset clears all valid bits and restores register defaults.
module radial_splat_brush_pixel #(
  parameter int MAX_SIDE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // px[11:0], py[23:12], old_texel[55:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // new_texel[31:0], weight[39:32]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [14:0] MAX_SIDE_V = 15'(MAX_SIDE);

  logic [24:0] cx_r, cz_r;
  logic [19:0] rad_r;
  logic [15:0] cell_r;
  logic [12:0] tw_r, th_r;
  logic [1:0]  ch_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cz_r   <= '0;
      rad_r  <= 20'd256;
      cell_r <= 16'd256;
      tw_r   <= 13'd1024;
      th_r   <= 13'd1024;
      ch_r   <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[4:2])
        rsb_pkg::REG_CENTER_X:  cx_r   <= cfg_pwdata[24:0];
        rsb_pkg::REG_CENTER_Z:  cz_r   <= cfg_pwdata[24:0];
        rsb_pkg::REG_RADIUS:    rad_r  <= cfg_pwdata[19:0];
        rsb_pkg::REG_CELL_SIZE: cell_r <= cfg_pwdata[15:0];
        rsb_pkg::REG_TEX_W:     tw_r   <= cfg_pwdata[12:0];
        rsb_pkg::REG_TEX_H:     th_r   <= cfg_pwdata[12:0];
        rsb_pkg::REG_CHANNEL:   ch_r   <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      rsb_pkg::REG_CENTER_X:  cfg_prdata = {7'd0, cx_r};
      rsb_pkg::REG_CENTER_Z:  cfg_prdata = {7'd0, cz_r};
      rsb_pkg::REG_RADIUS:    cfg_prdata = {12'd0, rad_r};
      rsb_pkg::REG_CELL_SIZE: cfg_prdata = {16'd0, cell_r};
      rsb_pkg::REG_TEX_W:     cfg_prdata = {19'd0, tw_r};
      rsb_pkg::REG_TEX_H:     cfg_prdata = {19'd0, th_r};
      rsb_pkg::REG_CHANNEL:   cfg_prdata = {30'd0, ch_r};
      default:                cfg_prdata = '0;
    endcase
  end

  logic [14:0] w_c, h_c;
  always_comb begin
    if (tw_r == '0) w_c = 15'd1;
    else if ({2'b0, tw_r} > MAX_SIDE_V) w_c = MAX_SIDE_V;
    else w_c = {2'b0, tw_r};
    if (th_r == '0) h_c = 15'd1;
    else if ({2'b0, th_r} > MAX_SIDE_V) h_c = MAX_SIDE_V;
    else h_c = {2'b0, th_r};
  end

  logic en;
  logic out_v_r;
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // stage 1: centered texel offsets
  logic               v1_r;
  logic signed [16:0] ax1_r, az1_r;
  logic [31:0]        old1_r;
  // stage 2: scaled world offsets
  logic               v2_r;
  logic signed [34:0] dx2_r, dz2_r;
  logic [31:0]        old2_r;
  // stage 3: magnitudes
  logic                       v3_r;
  logic [rsb_pkg::MAG_W-1:0]  mx3_r, mz3_r;
  logic [31:0]                old3_r;
  // stage 4: squares
  logic                        v4_r;
  logic [2*rsb_pkg::MAG_W-1:0] sx4_r, sz4_r;
  logic [31:0]                 old4_r;
  // stage 5: sum
  logic                      v5_r;
  logic [rsb_pkg::SQ_W-1:0]  sum5_r;
  logic [31:0]               old5_r;

  logic signed [16:0] ax1_nxt, az1_nxt;
  logic signed [33:0] mx2, mz2;
  logic signed [34:0] cx2, cz2, dx2_nxt, dz2_nxt;
  logic [34:0]        adx, adz;

  always_comb begin
    ax1_nxt = $signed({4'b0, in_tdata[11:0], 1'b0}) - $signed({2'b0, w_c}) + 17'sd1;
    az1_nxt = $signed({4'b0, in_tdata[23:12], 1'b0}) - $signed({2'b0, h_c}) + 17'sd1;
    mx2 = ax1_r * $signed({1'b0, cell_r});
    mz2 = az1_r * $signed({1'b0, cell_r});
    cx2 = $signed({{9{cx_r[24]}}, cx_r, 1'b0});
    cz2 = $signed({{9{cz_r[24]}}, cz_r, 1'b0});
    dx2_nxt = $signed({mx2[33], mx2}) - cx2;
    dz2_nxt = -$signed({mz2[33], mz2}) - cz2;
    adx = dx2_r[34] ? 35'(-dx2_r) : 35'(dx2_r);
    adz = dz2_r[34] ? 35'(-dz2_r) : 35'(dz2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r  <= ax1_nxt;
      az1_r  <= az1_nxt;
      old1_r <= in_tdata[55:24];
      dx2_r  <= dx2_nxt;
      dz2_r  <= dz2_nxt;
      old2_r <= old1_r;
      mx3_r  <= adx[rsb_pkg::MAG_W-1:0];
      mz3_r  <= adz[rsb_pkg::MAG_W-1:0];
      old3_r <= old2_r;
      sx4_r  <= mx3_r * mx3_r;
      sz4_r  <= mz3_r * mz3_r;
      old4_r <= old3_r;
      sum5_r <= {1'b0, sx4_r} + {1'b0, sz4_r};
      old5_r <= old4_r;
    end
  end

  logic                       vq;
  logic [rsb_pkg::ROOT_W-1:0] root;
  logic [31:0]                oldq;

  rsb_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_n      (sum5_r),
    .in_side   (old5_r),
    .out_valid (vq),
    .out_root  (root),
    .out_side  (oldq)
  );

  // stage 6: edge compare, scaled distance past the edge
  logic        v6_r, le6_r, ge6_r;
  logic [18:0] x6_r;
  logic [31:0] old6_r;
  // stage 7: smoothstep parameter
  logic        v7_r, le7_r, ge7_r;
  logic [15:0] t7_r;
  logic [31:0] old7_r;
  // stage 8: square of t
  logic        v8_r, le8_r, ge8_r;
  logic [15:0] t8_r;
  logic [31:0] tt8_r;
  logic [31:0] old8_r;
  // stage 9: smoothstep value
  logic        v9_r, le9_r, ge9_r;
  logic [16:0] s9_r;
  logic [31:0] old9_r;
  // output
  logic [31:0] new_r;
  logic [7:0]  wt_r;

  logic [31:0] edge_w, diff6;
  logic [37:0] p7;
  logic [17:0] k9;
  logic [49:0] p9;
  logic [16:0] inv10;
  logic [24:0] p10;
  logic [7:0]  w10, cur10;
  logic [31:0] new10;

  always_comb begin
    edge_w = {11'd0, rad_r, 1'b0};
    diff6  = root - edge_w;
    p7     = x6_r * rsb_pkg::RECIP_FIVE;
    k9     = rsb_pkg::SMOOTH_THREE - {1'b0, t8_r, 1'b0};
    p9     = tt8_r * k9;
    inv10  = rsb_pkg::UNIT_Q16 - s9_r;
    p10    = inv10 * rsb_pkg::WEIGHT_FULL;
    if (le9_r) w10 = rsb_pkg::WEIGHT_FULL;
    else if (ge9_r) w10 = '0;
    else w10 = p10[23:16];
    cur10 = old9_r[8*ch_r +: 8];
    new10 = old9_r;
    if (cur10 < w10) new10[8*ch_r +: 8] = w10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      v8_r    <= 1'b0;
      v9_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v6_r    <= vq;
      v7_r    <= v6_r;
      v8_r    <= v7_r;
      v9_r    <= v8_r;
      out_v_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      le6_r  <= root <= edge_w;
      ge6_r  <= diff6 >= rsb_pkg::FALLOFF_SPAN;
      x6_r   <= {diff6[11:0], 7'd0};
      old6_r <= oldq;
      le7_r  <= le6_r;
      ge7_r  <= ge6_r;
      t7_r   <= p7[36:21];
      old7_r <= old6_r;
      le8_r  <= le7_r;
      ge8_r  <= ge7_r;
      t8_r   <= t7_r;
      tt8_r  <= t7_r * t7_r;
      old8_r <= old7_r;
      le9_r  <= le8_r;
      ge9_r  <= ge8_r;
      s9_r   <= p9[48:32];
      old9_r <= old8_r;
      new_r  <= new10;
      wt_r   <= w10;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {wt_r, new_r};

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_blend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (new_r[8*ch_r +: 8] >= wt_r))
    else $error("selected byte below weight");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v9_r && le9_r) |=> (wt_r == rsb_pkg::WEIGHT_FULL))
    else $error("inside radius but weight not full");
`endif

endmodule

>>> hw/rtl/rsb_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module rsb_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rsb_pkg::SQ_W-1:0]    in_n,
  input  logic [rsb_pkg::SIDE_W-1:0]  in_side,
  output logic                        out_valid,
  output logic [rsb_pkg::ROOT_W-1:0]  out_root,
  output logic [rsb_pkg::SIDE_W-1:0]  out_side
);

  localparam int NST = rsb_pkg::ROOT_W;
  localparam int RW  = rsb_pkg::SQ_W + 1;

  logic [rsb_pkg::SQ_W-1:0]   n_r    [0:NST];
  logic [RW-1:0]              res_r  [0:NST];
  logic [rsb_pkg::SIDE_W-1:0] side_r [0:NST];
  logic                       vld_r  [0:NST];

  assign n_r[0]    = in_n;
  assign res_r[0]  = '0;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_valid;

  for (genvar g = 0; g < NST; g++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NST - 1 - g));
    logic [RW-1:0] trial;
    logic [RW-1:0] n_ext;
    logic [rsb_pkg::SQ_W-1:0] n_nxt;
    logic [RW-1:0] res_nxt;

    always_comb begin
      trial = res_r[g] + BIT;
      n_ext = {1'b0, n_r[g]};
      if (n_ext >= trial) begin
        n_nxt   = rsb_pkg::SQ_W'(n_ext - trial);
        res_nxt = (res_r[g] >> 1) + BIT;
      end else begin
        n_nxt   = n_r[g];
        res_nxt = res_r[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[g+1]    <= n_nxt;
        res_r[g+1]  <= res_nxt;
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_valid = vld_r[NST];
  assign out_root  = res_r[NST][rsb_pkg::ROOT_W-1:0];
  assign out_side  = side_r[NST];

endmodule
